@@ hdl/acs_pkg.sv @@
// ATA command setup: shared constants, opcodes, stage payload types.
// No dependencies; imported by the interfaces and all modules.
package acs_pkg;

   localparam int unsigned SECTOR_BYTES_DEFAULT = 512;

   // field widths
   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned DMA_BYTES_W = 17;
   localparam int unsigned CSR_INDEX_W = 2;

   // addressing
   localparam logic [ADDR_W-1:0] LBA48_START = 32'h1000_0000;
   localparam int unsigned ADDR28_W    = 28;
   localparam int unsigned CHS_SECTORS = 63;
   localparam int unsigned CHS_HEADS   = 16;
   localparam int unsigned HEAD_W      = $clog2(CHS_HEADS);

   // divide by 63: q ~= (addr * RECIP_63) >> RECIP_SHIFT, off by at most one low
   // (2^28 - 1) / 63 needs 23 quotient bits
   localparam int unsigned RECIP_W     = 29;
   localparam int unsigned RECIP_SHIFT = 34;
   localparam logic [RECIP_W-1:0] RECIP_63 = 29'd272696336;
   localparam int unsigned PROD_W      = ADDR28_W + RECIP_W;
   localparam int unsigned QUOT_W      = 23;
   localparam int unsigned REM_W       = 6;

   // device/head byte
   localparam logic [BYTE_W-1:0] DEV_HEAD_CHS = 8'hA0;
   localparam logic [BYTE_W-1:0] DEV_HEAD_LBA = 8'hE0;
   localparam int unsigned DRIVE_BIT = 4;

   // ATA opcodes
   localparam logic [BYTE_W-1:0] OP_READ_PIO      = 8'h20;
   localparam logic [BYTE_W-1:0] OP_READ_PIO_EXT  = 8'h24;
   localparam logic [BYTE_W-1:0] OP_READ_DMA      = 8'hC8;
   localparam logic [BYTE_W-1:0] OP_READ_DMA_EXT  = 8'h25;
   localparam logic [BYTE_W-1:0] OP_WRITE_PIO     = 8'h30;
   localparam logic [BYTE_W-1:0] OP_WRITE_PIO_EXT = 8'h34;
   localparam logic [BYTE_W-1:0] OP_WRITE_DMA     = 8'hCA;
   localparam logic [BYTE_W-1:0] OP_WRITE_DMA_EXT = 8'h35;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DMA_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LBA_SUPPORTED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_SLAVE   = 2'd2;

   typedef enum logic [1:0] {
      MODE_CHS   = 2'd0,
      MODE_LBA28 = 2'd1,
      MODE_LBA48 = 2'd2
   } addr_mode_type;

   // request after decode, carried down the pipe
   typedef struct packed {
      logic [BYTE_W-1:0]      opcode;
      addr_mode_type          mode;
      logic                   drive_slave;
      logic [ADDR_W-1:0]      block_address;
      logic [COUNT_W-1:0]     sector_count;
      logic [DMA_BYTES_W-1:0] dma_byte_count;
   } setup_type;

   // request plus address / 63 split
   typedef struct packed {
      setup_type          setup;
      logic [QUOT_W-1:0]  quotient;
      logic [REM_W-1:0]   remainder;
   } chs_type;

   function automatic logic [BYTE_W-1:0] pick_opcode(input logic ext, input logic dma,
                                                      input logic write);
      logic [BYTE_W-1:0] op;
      if (write) begin
         if (ext) op = dma ? OP_WRITE_DMA_EXT : OP_WRITE_PIO_EXT;
         else     op = dma ? OP_WRITE_DMA : OP_WRITE_PIO;
      end else begin
         if (ext) op = dma ? OP_READ_DMA_EXT : OP_READ_PIO_EXT;
         else     op = dma ? OP_READ_DMA : OP_READ_PIO;
      end
      return op;
   endfunction

endpackage

@@ hdl/acs_req_if.sv @@
// Request channel: valid/ready plus the sector request payload.
// Depends on acs_pkg.
interface acs_req_if;
   import acs_pkg::*;

   logic                valid;
   logic                ready;
   logic                command;
   logic [ADDR_W-1:0]   block_address;
   logic [COUNT_W-1:0]  sector_count;

   modport source (output valid, output command, output block_address,
                   output sector_count, input ready);
   modport sink   (input valid, input command, input block_address,
                   input sector_count, output ready);
endinterface

@@ hdl/acs_rsp_if.sv @@
// Response channel: valid/ready plus the taskfile values.
// Depends on acs_pkg.
interface acs_rsp_if;
   import acs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [BYTE_W-1:0]      ata_opcode;
   logic [BYTE_W-1:0]      device_head;
   logic [BYTE_W-1:0]      count_out;
   logic [BYTE_W-1:0]      addr_byte0;
   logic [BYTE_W-1:0]      addr_byte1;
   logic [BYTE_W-1:0]      addr_byte2;
   logic [BYTE_W-1:0]      addr_byte3;
   logic [1:0]             address_mode;
   logic [DMA_BYTES_W-1:0] dma_byte_count;

   modport source (output valid, output ata_opcode, output device_head, output count_out,
                   output addr_byte0, output addr_byte1, output addr_byte2,
                   output addr_byte3, output address_mode, output dma_byte_count,
                   input ready);
   modport sink   (input valid, input ata_opcode, input device_head, input count_out,
                   input addr_byte0, input addr_byte1, input addr_byte2,
                   input addr_byte3, input address_mode, input dma_byte_count,
                   output ready);
endinterface

@@ hdl/acs_csr_if.sv @@
// Configuration write channel: valid/ready, register index, write data.
// Depends on acs_pkg.
interface acs_csr_if;
   import acs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic                   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/acs_div63.sv @@
// Two-stage pipelined divide of the low 28 address bits by 63.
// Depends on acs_pkg; carries the decoded request alongside.
module acs_div63 (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  acs_pkg::setup_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output acs_pkg::chs_type  out_data
);
   import acs_pkg::*;

   // stage A: reciprocal product
   logic              a_valid_ff;
   setup_type         a_setup_ff;
   logic [PROD_W-1:0] a_prod_ff;
   logic [PROD_W-1:0] a_prod_in;
   logic              a_ready;

   // stage B: corrected quotient and remainder
   logic              b_valid_ff;
   chs_type           b_data_ff;
   chs_type           b_data_in;
   logic              b_ready;

   logic [ADDR28_W-1:0] b_addr;
   logic [QUOT_W-1:0]   q_est;
   logic [ADDR28_W-1:0] q_times63;
   logic [ADDR28_W-1:0] diff;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_prod_in = PROD_W'(in_data.block_address[ADDR28_W-1:0]) * PROD_W'(RECIP_63);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_setup_ff <= in_data;
         a_prod_ff  <= a_prod_in;
      end
   end

   // estimate is exact or one low; one compare and subtract fixes it
   always_comb begin
      b_addr    = a_setup_ff.block_address[ADDR28_W-1:0];
      q_est     = QUOT_W'(a_prod_ff >> RECIP_SHIFT);
      q_times63 = (ADDR28_W'(q_est) << REM_W) - ADDR28_W'(q_est);
      diff      = b_addr - q_times63;
      b_data_in.setup = a_setup_ff;
      if (diff >= ADDR28_W'(CHS_SECTORS)) begin
         b_data_in.quotient  = q_est + QUOT_W'(1);
         b_data_in.remainder = REM_W'(diff - ADDR28_W'(CHS_SECTORS));
      end else begin
         b_data_in.quotient  = q_est;
         b_data_in.remainder = REM_W'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_data.remainder < REM_W'(CHS_SECTORS)))
      else $error("div63 remainder out of range");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (out_valid && !out_ready))
      else $error("div63 stalled with a free stage");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
      else $error("div63 output changed while stalled");

endmodule

@@ hdl/ata_command_setup.sv @@
// ATA command setup, top level: request decode, divide pipeline, taskfile output.
// Depends on acs_pkg, acs_req_if, acs_rsp_if, acs_csr_if and acs_div63.

// Turns each sector request into ATA taskfile register values. One request is
// taken per clock when the response side keeps up; each request passes through
// the registered stages decode, reciprocal multiply, quotient correction and
// output register before its response transfer. The latency is set by the
// divide-by-63 used for CHS, done as a 28x29 reciprocal multiply followed by one
// correction step. Every stage holds while the stage after it is full and
// holding, and empty stages keep filling, so the input keeps taking transfers
// while a response waits, until every stage is full. Configuration (dma_enable,
// lba_supported, drive_slave) is written through the csr channel, always ready,
// and is sampled when a request enters decode. Addresses at or above 0x1000_0000
// go out as LBA48 with the ext opcodes; below that LBA28 is used when the drive
// supports it, else CHS on 16 heads x 63 sectors with the cylinder cut to 16
// bits. There is no reset sweep: the block is ready right after reset.
module ata_command_setup #(
   parameter int unsigned SECTOR_BYTES = acs_pkg::SECTOR_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   acs_req_if.sink    req_if,
   acs_rsp_if.source  rsp_if,
   acs_csr_if.sink    csr_if
);
   import acs_pkg::*;

   localparam int unsigned BYTES_W = COUNT_W + $clog2(SECTOR_BYTES + 1);
   localparam int unsigned FULL_W  = (BYTES_W > DMA_BYTES_W) ? BYTES_W : DMA_BYTES_W;

   // ---------------- configuration registers ----------------
   logic dma_enable_ff;
   logic lba_supported_ff;
   logic drive_slave_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dma_enable_ff    <= 1'b0;
         lba_supported_ff <= 1'b0;
         drive_slave_ff   <= 1'b0;
      end else if (csr_if.valid) begin
         // indexes past the list are dropped
         case (csr_if.index)
            CSR_DMA_ENABLE:    dma_enable_ff    <= csr_if.data;
            CSR_LBA_SUPPORTED: lba_supported_ff <= csr_if.data;
            CSR_DRIVE_SLAVE:   drive_slave_ff   <= csr_if.data;
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: decode ----------------
   logic              s1_valid_ff;
   setup_type         s1_data_ff;
   setup_type         s1_data_in;
   logic              s1_ready;
   logic              div_in_ready;
   logic              is_ext;
   logic [FULL_W-1:0] bytes_full;

   assign s1_ready     = !s1_valid_ff || div_in_ready;
   assign req_if.ready = s1_ready;

   always_comb begin
      is_ext     = (req_if.block_address >= LBA48_START);
      bytes_full = FULL_W'(req_if.sector_count) * FULL_W'(SECTOR_BYTES);

      s1_data_in.block_address = req_if.block_address;
      s1_data_in.sector_count  = req_if.sector_count;
      s1_data_in.drive_slave   = drive_slave_ff;
      s1_data_in.opcode        = pick_opcode(is_ext, dma_enable_ff, req_if.command);
      if (is_ext)                s1_data_in.mode = MODE_LBA48;
      else if (lba_supported_ff) s1_data_in.mode = MODE_LBA28;
      else                       s1_data_in.mode = MODE_CHS;
      // product keeps its low 17 bits for large sector sizes
      s1_data_in.dma_byte_count = dma_enable_ff ? bytes_full[DMA_BYTES_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_if.valid) begin
         s1_data_ff <= s1_data_in;
      end
   end

   // ---------------- stages 2-3: address / 63 ----------------
   logic    div_out_valid;
   logic    out_ready;
   chs_type div_out;

   acs_div63 u_div63 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (div_in_ready),
      .in_data   (s1_data_ff),
      .out_valid (div_out_valid),
      .out_ready (out_ready),
      .out_data  (div_out)
   );

   // ---------------- stage 4: taskfile format ----------------
   logic                   rsp_valid_ff;
   logic [BYTE_W-1:0]      opcode_ff,     opcode_in;
   logic [BYTE_W-1:0]      dev_head_ff,   dev_head_in;
   logic [BYTE_W-1:0]      count_ff;
   logic [BYTE_W-1:0]      byte0_ff,      byte0_in;
   logic [BYTE_W-1:0]      byte1_ff,      byte1_in;
   logic [BYTE_W-1:0]      byte2_ff,      byte2_in;
   logic [BYTE_W-1:0]      byte3_ff,      byte3_in;
   logic [1:0]             mode_ff;
   logic [DMA_BYTES_W-1:0] dma_bytes_ff;

   logic [ADDR_W-1:0]      lba;
   logic [HEAD_W-1:0]      head;
   logic [BYTE_W-1:0]      head_base;
   logic [QUOT_W-1:0]      cylinder;

   assign out_ready = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      lba       = div_out.setup.block_address;
      // cylinder = address / 1008 = (address / 63) / 16, low 16 bits kept
      cylinder  = div_out.quotient >> HEAD_W;
      opcode_in = div_out.setup.opcode;
      head_base = DEV_HEAD_LBA;
      head      = '0;
      byte0_in  = lba[7:0];
      byte1_in  = lba[15:8];
      byte2_in  = lba[23:16];
      byte3_in  = '0;
      if (div_out.setup.mode == MODE_LBA48) begin
         byte3_in = lba[31:24];
      end else if (div_out.setup.mode == MODE_LBA28) begin
         head = lba[ADDR28_W-1:ADDR28_W-HEAD_W];
      end else begin
         head_base = DEV_HEAD_CHS;
         head      = div_out.quotient[HEAD_W-1:0];
         byte0_in  = BYTE_W'(div_out.remainder) + BYTE_W'(1);
         byte1_in  = cylinder[7:0];
         byte2_in  = cylinder[15:8];
      end
      dev_head_in = head_base | (BYTE_W'(div_out.setup.drive_slave) << DRIVE_BIT)
                  | BYTE_W'(head);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_out_valid) begin
         opcode_ff    <= opcode_in;
         dev_head_ff  <= dev_head_in;
         count_ff     <= div_out.setup.sector_count;
         byte0_ff     <= byte0_in;
         byte1_ff     <= byte1_in;
         byte2_ff     <= byte2_in;
         byte3_ff     <= byte3_in;
         mode_ff      <= div_out.setup.mode;
         dma_bytes_ff <= div_out.setup.dma_byte_count;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.ata_opcode     = opcode_ff;
   assign rsp_if.device_head    = dev_head_ff;
   assign rsp_if.count_out      = count_ff;
   assign rsp_if.addr_byte0     = byte0_ff;
   assign rsp_if.addr_byte1     = byte1_ff;
   assign rsp_if.addr_byte2     = byte2_ff;
   assign rsp_if.addr_byte3     = byte3_ff;
   assign rsp_if.address_mode   = mode_ff;
   assign rsp_if.dma_byte_count = dma_bytes_ff;

   // ---------------- checks ----------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
      else $error("request stalled while the pipe has room");

   a_chs_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.address_mode == MODE_CHS) |->
         (rsp_if.addr_byte0 != '0 && rsp_if.addr_byte0 <= BYTE_W'(CHS_SECTORS)
          && rsp_if.addr_byte3 == '0
          && rsp_if.device_head[7:5] == DEV_HEAD_CHS[7:5]))
      else $error("CHS taskfile values out of range");

   a_lba48_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.address_mode == MODE_LBA48) |->
         (rsp_if.device_head[3:0] == '0
          && (rsp_if.ata_opcode == OP_READ_PIO_EXT || rsp_if.ata_opcode == OP_READ_DMA_EXT
              || rsp_if.ata_opcode == OP_WRITE_PIO_EXT
              || rsp_if.ata_opcode == OP_WRITE_DMA_EXT)))
      else $error("LBA48 taskfile without ext opcode or with head bits");

endmodule

@@ verif/acs_taskfile_checker.sv @@
// Taskfile checker: watches the request, response and csr channels of
// ata_command_setup, predicts each taskfile and compares it field by field.
// Depends on acs_pkg and the acs_req_if, acs_rsp_if and acs_csr_if interfaces.
module acs_taskfile_checker #(
   parameter int unsigned SECTOR_BYTES = acs_pkg::SECTOR_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   acs_req_if          req,
   acs_rsp_if          rsp,
   acs_csr_if          csr,
   output int unsigned failures,
   output int unsigned pending
);
   import acs_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0]      opcode;
      logic [BYTE_W-1:0]      device_head;
      logic [BYTE_W-1:0]      count_out;
      logic [BYTE_W-1:0]      addr0;
      logic [BYTE_W-1:0]      addr1;
      logic [BYTE_W-1:0]      addr2;
      logic [BYTE_W-1:0]      addr3;
      addr_mode_type          mode;
      logic [DMA_BYTES_W-1:0] dma_bytes;
   } taskfile_type;

   taskfile_type expected_taskfiles[$];

   // shadow copy of the configuration registers
   logic dma_en;
   logic lba_ok;
   logic slave_sel;

   function automatic taskfile_type predict_taskfile(input logic write,
                                                     input logic [ADDR_W-1:0] lba,
                                                     input logic [COUNT_W-1:0] cnt);
      taskfile_type tf;
      logic [31:0] cyl;
      logic [31:0] sect;
      logic [31:0] bytes;
      logic [3:0]  head;
      logic [BYTE_W-1:0] base;
      if (lba >= LBA48_START) begin
         tf.mode  = MODE_LBA48;
         tf.addr0 = lba[7:0];
         tf.addr1 = lba[15:8];
         tf.addr2 = lba[23:16];
         tf.addr3 = lba[31:24];
         head     = 4'd0;
      end else if (lba_ok) begin
         tf.mode  = MODE_LBA28;
         tf.addr0 = lba[7:0];
         tf.addr1 = lba[15:8];
         tf.addr2 = lba[23:16];
         tf.addr3 = '0;
         head     = lba[27:24];
      end else begin
         // cylinder keeps only its low 16 bits
         cyl      = lba / (CHS_HEADS * CHS_SECTORS);
         sect     = lba % CHS_SECTORS + 1;
         head     = 4'((lba / CHS_SECTORS) % CHS_HEADS);
         tf.mode  = MODE_CHS;
         tf.addr0 = sect[7:0];
         tf.addr1 = cyl[7:0];
         tf.addr2 = cyl[15:8];
         tf.addr3 = '0;
      end

      if (tf.mode == MODE_LBA48) begin
         if (write) tf.opcode = dma_en ? OP_WRITE_DMA_EXT : OP_WRITE_PIO_EXT;
         else       tf.opcode = dma_en ? OP_READ_DMA_EXT : OP_READ_PIO_EXT;
      end else begin
         if (write) tf.opcode = dma_en ? OP_WRITE_DMA : OP_WRITE_PIO;
         else       tf.opcode = dma_en ? OP_READ_DMA : OP_READ_PIO;
      end

      base = (tf.mode == MODE_CHS) ? DEV_HEAD_CHS : DEV_HEAD_LBA;
      base[DRIVE_BIT] = slave_sel;
      tf.device_head  = base | {4'd0, head};
      tf.count_out    = cnt;
      bytes           = dma_en ? 32'(cnt) * SECTOR_BYTES : 32'd0;
      tf.dma_bytes    = bytes[DMA_BYTES_W-1:0];
      return tf;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] taskfile mismatch: %s", $realtime, msg);
      failures++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      taskfile_type want;
      if (reset) begin
         dma_en    = 1'b0;
         lba_ok    = 1'b0;
         slave_sel = 1'b0;
         failures  = 0;
         expected_taskfiles.delete();
         pending  <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_taskfiles.size() == 0) begin
               report_mismatch("response transfer with no request outstanding");
            end else begin
               want = expected_taskfiles.pop_front();
               compare_field("ata_opcode", rsp.ata_opcode, want.opcode);
               compare_field("device_head", rsp.device_head, want.device_head);
               compare_field("count_out", rsp.count_out, want.count_out);
               compare_field("addr_byte0", rsp.addr_byte0, want.addr0);
               compare_field("addr_byte1", rsp.addr_byte1, want.addr1);
               compare_field("addr_byte2", rsp.addr_byte2, want.addr2);
               compare_field("addr_byte3", rsp.addr_byte3, want.addr3);
               compare_field("address_mode", rsp.address_mode, want.mode);
               compare_field("dma_byte_count", rsp.dma_byte_count, want.dma_bytes);
            end
         end
         // predict with the settings in force before this edge's csr write
         if (req.valid && req.ready)
            expected_taskfiles.push_back(predict_taskfile(req.command, req.block_address,
                                                          req.sector_count));
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_DMA_ENABLE:    dma_en    = csr.data;
               CSR_LBA_SUPPORTED: lba_ok    = csr.data;
               CSR_DRIVE_SLAVE:   slave_sel = csr.data;
               default: ;
            endcase
         end
         pending <= expected_taskfiles.size();
      end
   end

endmodule

@@ verif/testbench.sv @@
// Top of the ata_command_setup testbench: clock, reset, request and csr
// stimulus, response back-pressure, watchdog and verdict.
// Depends on acs_pkg, the acs_*_if interfaces, ata_command_setup, acs_taskfile_checker.
module testbench;
   import acs_pkg::*;

   // index past the end of the register list; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int unsigned RESET_CYCLES    = 9;
   localparam int unsigned IDLE_LIMIT      = 1000;  // cycles with no transfer at all
   localparam int unsigned SETTLE_CYCLES   = 8;     // pipe is four deep
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned ITEMS_PER_PHASE = 97;

   // back-pressure patterns on the response side
   typedef enum logic [1:0] {
      RX_STREAM,     // always ready
      RX_COIN,       // ready on a coin toss each cycle
      RX_PERIODIC,   // ready unless the countdown is a multiple of four
      RX_STARVE      // single ready cycle between long stalls
   } rx_pattern_type;

   logic        clock;
   logic        reset;
   int unsigned failures;
   int unsigned pending;      // requests still waiting for their response
   int unsigned idle_cycles;
   int unsigned burst_left;   // request transfers left in the current burst

   acs_req_if req();
   acs_rsp_if rsp();
   acs_csr_if csr();

   ata_command_setup dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   acs_taskfile_checker taskfile_check (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .csr      (csr),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a healthy run never goes long without some transfer.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Response side: switch to a randomly chosen stall pattern whenever the current one runs out.
   initial begin
      rx_pattern_type rx_mode;
      int unsigned mode_left;
      int unsigned stall_run;
      rx_mode   = RX_STREAM;
      mode_left = 0;
      stall_run = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            rx_mode   = rx_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 200);
         end
         mode_left--;
         case (rx_mode)
            RX_STREAM:   rsp.ready <= 1'b1;
            RX_COIN:     rsp.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp.ready <= (mode_left % 4) != 0;
            default: begin
               if (stall_run == 0) begin
                  stall_run = $urandom_range(2, 16);
                  rsp.ready <= 1'b1;
               end else begin
                  stall_run--;
                  rsp.ready <= 1'b0;
               end
            end
         endcase
      end
   end

   // Mostly short bursts, now and then a long uninterrupted stretch.
   function automatic int unsigned new_burst();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
   endfunction

   // Holds valid high across back-to-back transfers; only drops it for a gap.
   task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] lba,
                               input logic [COUNT_W-1:0] cnt);
      int unsigned gap;
      req.valid         <= 1'b1;
      req.command       <= cmd;
      req.block_address <= lba;
      req.sector_count  <= cnt;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
         burst_left = new_burst();
      end
   endtask

   // Stop sending and wait until every outstanding response has come back.
   // The first edge is always taken so that pending covers the last transfer.
   task automatic drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      burst_left = new_burst();
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
   endtask

   // Only called with the pipe empty. Ends with a write to the unmapped
   // index, which must leave all three settings alone.
   task automatic configure(input logic dma, input logic lba, input logic slave);
      write_register(CSR_DMA_ENABLE, dma);
      write_register(CSR_LBA_SUPPORTED, lba);
      write_register(CSR_DRIVE_SLAVE, slave);
      write_register(CSR_UNMAPPED, 1'($urandom_range(0, 1)));
      csr.valid <= 1'b0;
   endtask

   // Address mix: LBA28 range, the LBA48 boundary, small CHS addresses, full 32 bits.
   task automatic send_random();
      logic [ADDR_W-1:0]  lba;
      logic [COUNT_W-1:0] cnt;
      case ($urandom_range(0, 9))
         0, 1, 2: lba = $urandom_range(0, 32'h0FFF_FFFF);
         3:       lba = $urandom_range(32'h0FFF_FF00, 32'h1000_00FF);
         4, 5:    lba = $urandom_range(0, 20000);
         default: lba = $urandom();
      endcase
      case ($urandom_range(0, 9))
         0:       cnt = '0;
         1:       cnt = '1;
         default: cnt = COUNT_W'($urandom_range(0, 255));
      endcase
      send_request(1'($urandom_range(0, 1)), lba, cnt);
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      req.valid         <= 1'b0;
      req.command       <= 1'b0;
      req.block_address <= '0;
      req.sector_count  <= '0;
      csr.valid         <= 1'b0;
      csr.index         <= CSR_DMA_ENABLE;
      csr.data          <= 1'b0;
      reset             <= 1'b1;
      burst_left = new_burst();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: CHS, PIO, master. Sector wrap at 63, cylinder step
      // at 1008, zero count, and a cylinder too big for 16 bits.
      send_request(1'b0, 32'h0000_0000, 8'h00);
      send_request(1'b1, 32'h0FFF_FFFF, 8'hFF);
      send_request(1'b0, 32'd62, 8'h01);
      send_request(1'b0, 32'd63, 8'h02);
      send_request(1'b1, 32'd1007, 8'h03);
      send_request(1'b1, 32'd1008, 8'h04);
      send_request(1'b1, LBA48_START, 8'h80);
      send_request(1'b0, 32'hFFFF_FFFF, 8'hFF);

      // Everything on: LBA28 with slave bit, DMA opcodes and byte count,
      // both sides of the LBA48 boundary.
      drain();
      configure(1'b1, 1'b1, 1'b1);
      send_request(1'b0, 32'h0FFF_FFFF, 8'hFF);
      send_request(1'b1, 32'h0123_4567, 8'h00);
      send_request(1'b1, LBA48_START, 8'hFF);
      send_request(1'b0, 32'hFFFF_FFFF, 8'h00);
      send_request(1'b1, 32'hA5A5_5A5A, 8'h55);
      send_request(1'b0, 32'h5A5A_A5A5, 8'hAA);

      // DMA over CHS.
      drain();
      configure(1'b1, 1'b0, 1'b0);
      send_request(1'b0, 32'h0FFF_FFFF, 8'hFF);
      send_request(1'b1, 32'd16127, 8'h01);
      send_request(1'b0, 32'hDEAD_BEEF, 8'hFF);
      send_request(1'b1, 32'h0000_03EF, 8'h7F);

      // PIO LBA28 on the slave.
      drain();
      configure(1'b0, 1'b1, 1'b1);
      send_request(1'b0, 32'h0800_0000, 8'h01);
      send_request(1'b1, 32'hFFFF_FFFF, 8'hFE);
      send_request(1'b1, 32'h0000_0000, 8'hFF);

      // Random phases, each under a fresh random setting; an occasional
      // full drain mid-phase on top of the one before each csr update.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random();
            if ($urandom_range(0, 149) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
